@@ hdl/assert_macros.svh @@
// assertion macros shared by the link-state table modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while reset is asserted
`define LSDB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// invariant checked on every rising edge, off while reset is asserted
`define LSDB_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

@@ hdl/lsdb_pkg.sv @@
// shared types and constants of the link-state table
package lsdb_pkg;

    localparam int unsigned LSDB_MAX_ENTRIES   = 32;
    localparam int unsigned LSDB_IDX_OUT_W     = 5;
    localparam logic [15:0] LSDB_AGE_LIMIT_RST = 16'd1500;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } t_command;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] seq;
        logic [31:0] stamp;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the input transaction
        logic scan_start;  // read slot 0
        logic scan_step;   // move on to the next slot
        logic finish;      // decide, write back, load the result register
        logic hit;         // key was found by the scan
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic match;       // slot under compare holds the key
        logic last;        // slot under compare is the last valid one
    } t_dp_status;

endpackage

@@ hdl/lsdb_datapath.sv @@
// entry memory, scan pointer, entry count, age limit register and result registers
`include "assert_macros.svh"

module lsdb_datapath
    import lsdb_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = LSDB_MAX_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic                      i_command,
    input  logic [31:0]               i_node_ip,
    input  logic [15:0]               i_node_port,
    input  logic [31:0]               i_seq_num,
    input  logic [31:0]               i_now_ms,
    input  logic                      i_cfg_we,
    input  logic [15:0]               i_cfg_data,
    output logic                      o_accepted,
    output logic                      o_found,
    output logic [LSDB_IDX_OUT_W-1:0] o_entry_index,
    output logic                      o_alive
);

    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    t_entry          r_mem [MAX_ENTRIES];
    t_entry          r_rd_data;
    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   r_scan_idx;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [15:0]     r_age_limit;

    logic            r_cmd;
    logic [31:0]     r_ip;
    logic [15:0]     r_port;
    logic [31:0]     r_seq;
    logic [31:0]     r_now;

    logic            full;
    logic            is_update;
    logic            we;
    logic [IW-1:0]   waddr;
    t_entry          wdata;
    logic [31:0]     age;
    logic            n_accepted;
    logic            n_alive;
    logic [IW-1:0]   n_slot;

    // read address: slot 0 on start, next slot on step, otherwise hold
    always_comb begin
        if (i_cmd.scan_start) begin
            rd_addr = '0;
        end else if (i_cmd.scan_step) begin
            rd_addr = r_scan_idx + 1'b1;
        end else begin
            rd_addr = r_scan_idx;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.match      = (r_rd_data.ip == r_ip) && (r_rd_data.port == r_port);
    assign o_status.last       = ((CW'(r_scan_idx) + CW'(1)) == r_count);

    assign full      = (r_count == CW'(MAX_ENTRIES));
    assign is_update = (r_cmd == CMD_UPDATE);
    assign age       = r_now - r_rd_data.stamp;

    always_comb begin
        we          = 1'b0;
        waddr       = r_scan_idx;
        wdata.ip    = r_ip;
        wdata.port  = r_port;
        wdata.seq   = r_seq;
        wdata.stamp = r_now;
        n_accepted  = 1'b0;
        n_alive     = 1'b0;
        n_slot      = '0;
        n_count     = r_count;
        if (is_update) begin
            if (!i_cmd.hit) begin
                if (!full) begin
                    we         = 1'b1;
                    waddr      = r_count[IW-1:0];
                    n_accepted = 1'b1;
                    n_slot     = r_count[IW-1:0];
                    n_count    = r_count + 1'b1;
                end
            end else begin
                n_slot = r_scan_idx;
                // strictly newer sequence refreshes seq and stamp
                if (r_seq > r_rd_data.seq) begin
                    we         = 1'b1;
                    n_accepted = 1'b1;
                end
            end
        end else if (i_cmd.hit) begin
            n_slot  = r_scan_idx;
            n_alive = (age <= {16'd0, r_age_limit});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_age_limit <= LSDB_AGE_LIMIT_RST;
            r_scan_idx  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_age_limit <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
            r_scan_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_ip   <= i_node_ip;
            r_port <= i_node_port;
            r_seq  <= i_seq_num;
            r_now  <= i_now_ms;
        end
        if (i_cmd.finish) begin
            o_accepted    <= n_accepted;
            o_found       <= i_cmd.hit;
            o_entry_index <= LSDB_IDX_OUT_W'(n_slot);
            o_alive       <= n_alive;
        end
    end

    `LSDB_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_ENTRIES),
        "entry count above table depth")
    `LSDB_ASSERT(a_step_in_range, i_clk, i_rst_n,
        i_cmd.scan_step |-> ((CW'(r_scan_idx) + CW'(1)) < r_count),
        "scan stepped past the valid entries")
    `LSDB_ASSERT(a_insert_count, i_clk, i_rst_n,
        (i_cmd.finish && is_update && !i_cmd.hit && !full) |=> (r_count == $past(r_count) + 1'b1),
        "insert did not grow the entry count")

endmodule

@@ hdl/lsdb_ctrl.sv @@
// sequencer: accept, linear scan over valid entries, decide and hand off the result
`include "assert_macros.svh"

module lsdb_ctrl
    import lsdb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_hit;
    logic   in_xact;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign in_xact  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.hit        = r_hit;
        o_cmd.load       = in_xact;
        o_cmd.scan_start = in_xact;
        o_cmd.scan_step  = (r_state == S_SCAN) && !i_status.match && !i_status.last;
        o_cmd.finish     = (r_state == S_FIN) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        r_hit   <= 1'b0;
                        r_state <= i_status.count_zero ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_status.match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FIN;
                    end else if (i_status.last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `LSDB_ASSERT(a_match_to_fin, i_clk, i_rst_n,
        (r_state == S_SCAN && i_status.match) |=> (r_state == S_FIN && r_hit),
        "scan hit not carried into decide")
    `LSDB_ASSERT(a_one_in_flight, i_clk, i_rst_n, in_xact |=> !o_ready,
        "second transaction taken while one is in flight")
    `LSDB_ASSERT(a_result_held, i_clk, i_rst_n, (r_out_valid && !i_ready) |=> r_out_valid,
        "result dropped before it was taken")

endmodule

@@ hdl/link_state_database.sv @@
// link-state advertisement table: top level
// Each transaction is an update or a liveness query keyed by node address and port.
// The table is searched linearly from slot 0, one entry per cycle through a single
// registered-read memory port. A scan covers from 1 entry up to the fill count (at
// most MAX_ENTRIES; no entries for an empty table); the decide step then registers
// the result and returns the block to idle, and it waits while the previous result
// is still held by the sink. One transaction is in flight at a time; the result
// register lets the next transaction be accepted while the previous result waits.
// Updates append new keys while there is room and refresh an entry only for a
// strictly larger sequence number; a query reports alive when now_ms minus the
// stored stamp (mod 2^32) is at most the age limit register (reset 1500 ms).
// Configuration is always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. entry_index carries the low 5
// bits of the slot.
module link_state_database
    import lsdb_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = LSDB_MAX_ENTRIES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_command,
    input  logic [31:0]               i_node_ip,
    input  logic [15:0]               i_node_port,
    input  logic [31:0]               i_seq_num,
    input  logic [31:0]               i_now_ms,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_accepted,
    output logic                      o_found,
    output logic [LSDB_IDX_OUT_W-1:0] o_entry_index,
    output logic                      o_alive,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [15:0]               i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    lsdb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    lsdb_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_command     (i_command),
        .i_node_ip     (i_node_ip),
        .i_node_port   (i_node_port),
        .i_seq_num     (i_seq_num),
        .i_now_ms      (i_now_ms),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_accepted    (o_accepted),
        .o_found       (o_found),
        .o_entry_index (o_entry_index),
        .o_alive       (o_alive)
    );

endmodule
